// File: sv/bcc_pkg.sv
// Shared types, constants and register codes for the button click classifier.
package bcc_pkg;

    // Fixed field layout of the stream words
    localparam int FIELD_KEYS   = 4;
    localparam int LEVEL_W      = 4;
    localparam int KEY_IDX_W    = 2;
    localparam int STATUS_W     = 2;
    localparam int CNT_W        = 8;
    localparam int MASK_W       = 4;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 8;
    localparam int IN_DATA_W    = 8;
    localparam int OUT_DATA_W   = 8;

    localparam int NUM_KEYS_DEF = 4;

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    // Status codes
    localparam logic [STATUS_W-1:0] ST_NONE   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_SINGLE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_DOUBLE = 2'd2;
    localparam logic [STATUS_W-1:0] ST_LONG   = 2'd3;

    // Item kinds carried in tuser
    localparam logic ACT_TICK  = 1'b0;
    localparam logic ACT_WRITE = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_LONG_EN   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DOUBLE_EN = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SINGLE_EN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_TKS  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DWIN_TKS  = 3'd4;

    // Register reset values
    localparam logic [MASK_W-1:0] RST_LONG_EN   = 4'd1;
    localparam logic [MASK_W-1:0] RST_DOUBLE_EN = 4'd1;
    localparam logic [MASK_W-1:0] RST_SINGLE_EN = 4'd15;
    localparam logic [CNT_W-1:0]  RST_LONG_TKS  = 8'd100;
    localparam logic [CNT_W-1:0]  RST_DWIN_TKS  = 8'd30;

    typedef enum logic [2:0] {
        PH_IDLE     = 3'd0,
        PH_PRESSED  = 3'd1,
        PH_LONG     = 3'd2,
        PH_RELEASED = 3'd3,
        PH_DWAIT    = 3'd4,
        PH_SECOND   = 3'd5
    } phase_t;

    typedef struct packed {
        logic [MASK_W-1:0] long_en;
        logic [MASK_W-1:0] double_en;
        logic [MASK_W-1:0] single_en;
        logic [CNT_W-1:0]  long_ticks;
        logic [CNT_W-1:0]  dwin_ticks;
    } cfg_t;

    // Per-key view of the configuration
    typedef struct packed {
        logic             en_long;
        logic             en_double;
        logic             en_single;
        logic [CNT_W-1:0] long_ticks;
        logic [CNT_W-1:0] dwin_ticks;
    } key_cfg_t;

    // Per-key control from the top level
    typedef struct packed {
        logic tick_en;
        logic write_en;
        logic pressed;
        logic write_val;
    } key_ctl_t;

    function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] c);
        bump = (c == CNT_MAX) ? CNT_MAX : c + 1'b1;
    endfunction

endpackage

// File: sv/bcc_key_cell.sv
// One key's press classifier: phase, tick counter and sticky status.
module bcc_key_cell (
    input  logic                           clk,
    input  logic                           rst_n,
    input  bcc_pkg::key_cfg_t              kcfg,
    input  bcc_pkg::key_ctl_t              ctl,
    output logic [bcc_pkg::STATUS_W-1:0]   status_next
);
    import bcc_pkg::*;

    phase_t              phase_reg, phase_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [STATUS_W-1:0] status_reg;
    logic [CNT_W-1:0]    cnt_inc;

    assign cnt_inc = bump(cnt_reg);

    // Next phase
    always_comb
    begin
        phase_next = phase_reg;
        if (ctl.tick_en)
        begin
            unique case (phase_reg)
                PH_PRESSED:
                begin
                    if (!ctl.pressed)
                        phase_next = PH_RELEASED;
                    else if (cnt_inc >= kcfg.long_ticks && kcfg.en_long)
                        phase_next = PH_LONG;
                end
                PH_LONG:
                begin
                    if (!ctl.pressed)
                        phase_next = PH_IDLE;
                end
                PH_RELEASED:
                begin
                    if (!ctl.pressed)
                        phase_next = kcfg.en_double ? PH_DWAIT : PH_IDLE;
                end
                PH_DWAIT:
                begin
                    if (ctl.pressed)
                        phase_next = PH_SECOND;
                    else if (cnt_inc >= kcfg.dwin_ticks)
                        phase_next = PH_IDLE;
                end
                PH_SECOND:
                begin
                    if (!ctl.pressed)
                        phase_next = PH_IDLE;
                end
                default:
                begin
                    phase_next = ctl.pressed ? PH_PRESSED : PH_IDLE;
                end
            endcase
        end
    end

    // Counter and status
    always_comb
    begin
        cnt_next    = cnt_reg;
        status_next = status_reg;
        if (ctl.write_en)
            status_next = {1'b0, ctl.write_val};
        if (ctl.tick_en)
        begin
            unique case (phase_reg)
                PH_PRESSED:
                begin
                    cnt_next = cnt_inc;
                end
                PH_LONG:
                begin
                    if (!ctl.pressed)
                    begin
                        cnt_next    = '0;
                        status_next = ST_LONG;
                    end
                end
                PH_RELEASED:
                begin
                    if (!ctl.pressed)
                    begin
                        if (kcfg.en_double)
                            cnt_next = cnt_inc;
                        else
                        begin
                            cnt_next    = '0;
                            status_next = kcfg.en_single ? ST_SINGLE : ST_NONE;
                        end
                    end
                end
                PH_DWAIT:
                begin
                    if (!ctl.pressed)
                    begin
                        if (cnt_inc >= kcfg.dwin_ticks)
                        begin
                            cnt_next = '0;
                            if (kcfg.en_single)
                                status_next = ST_SINGLE;
                        end
                        else
                            cnt_next = cnt_inc;
                    end
                end
                PH_SECOND:
                begin
                    if (!ctl.pressed)
                    begin
                        cnt_next    = '0;
                        status_next = ST_DOUBLE;
                    end
                end
                default:
                begin
                    if (ctl.pressed)
                        cnt_next = cnt_inc;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            cnt_reg    <= '0;
            status_reg <= ST_NONE;
        end
        else
        begin
            phase_reg  <= phase_next;
            cnt_reg    <= cnt_next;
            status_reg <= status_next;
        end
    end

endmodule

// File: sv/button_click_classifier_top.sv
// Top level of the button click classifier: stream ports, configuration and key cells.
// The statuses of an accepted word are registered and show on m_tdata from the next cycle.
// Throughput: one word per cycle; s_tready stays high while the result register is
// empty or being drained, so a word may enter every cycle.
// Reset: rst_n clears every key to idle with a zero counter and status, empties the
// result register and loads the configuration registers with their defaults.
module button_click_classifier_top #(
    parameter int NUM_KEYS = bcc_pkg::NUM_KEYS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // Input stream
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // [3:0] key_levels, [5:4] key_index, [6] status_value, [7] zero
    input  logic [bcc_pkg::IN_DATA_W-1:0]    s_tdata,
    // [0] action
    input  logic                             s_tuser,
    // Result stream
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [1:0] status_key0, [3:2] status_key1, [5:4] status_key2, [7:6] status_key3
    output logic [bcc_pkg::OUT_DATA_W-1:0]   m_tdata,
    // Configuration writes
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [bcc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [bcc_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import bcc_pkg::*;

    // Only the first four keys have a level bit; further keys read released with every
    // feature off, so they never leave idle and need no hardware.
    localparam int NUM_CELLS = (NUM_KEYS < FIELD_KEYS) ? NUM_KEYS : FIELD_KEYS;

    cfg_t                      cfg_reg;
    logic                      m_tvalid_reg, m_tvalid_next;
    logic [OUT_DATA_W-1:0]     m_tdata_reg;
    logic                      s_accept;
    logic                      action;
    logic [LEVEL_W-1:0]        key_levels;
    logic [KEY_IDX_W-1:0]      key_index;
    logic                      status_value;
    logic [STATUS_W-1:0]       status_w [FIELD_KEYS];
    logic [OUT_DATA_W-1:0]     result_w;

    // Unpack the input word
    assign action       = s_tuser;
    assign key_levels   = s_tdata[LEVEL_W-1:0];
    assign key_index    = s_tdata[LEVEL_W +: KEY_IDX_W];
    assign status_value = s_tdata[LEVEL_W + KEY_IDX_W];

    // Take a new word whenever the result register is free or drains this cycle
    assign s_tready = !m_tvalid_reg || m_tready;
    assign s_accept = s_tvalid && s_tready;

    // Configuration is always writable; unknown indexes are dropped
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.long_en    <= RST_LONG_EN;
            cfg_reg.double_en  <= RST_DOUBLE_EN;
            cfg_reg.single_en  <= RST_SINGLE_EN;
            cfg_reg.long_ticks <= RST_LONG_TKS;
            cfg_reg.dwin_ticks <= RST_DWIN_TKS;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_LONG_EN:   cfg_reg.long_en    <= cfg_data[MASK_W-1:0];
                REG_DOUBLE_EN: cfg_reg.double_en  <= cfg_data[MASK_W-1:0];
                REG_SINGLE_EN: cfg_reg.single_en  <= cfg_data[MASK_W-1:0];
                REG_LONG_TKS:  cfg_reg.long_ticks <= cfg_data[CNT_W-1:0];
                REG_DWIN_TKS:  cfg_reg.dwin_ticks <= cfg_data[CNT_W-1:0];
                default:       ;
            endcase
        end
    end

    // One classifier cell per present key; each advances only on an accepted tick word
    // and takes a status write only when the word names it.
    for (genvar k = 0; k < NUM_CELLS; k++)
    begin : g_cell
        key_cfg_t kcfg;
        key_ctl_t kctl;

        assign kcfg.en_long    = cfg_reg.long_en[k];
        assign kcfg.en_double  = cfg_reg.double_en[k];
        assign kcfg.en_single  = cfg_reg.single_en[k];
        assign kcfg.long_ticks = cfg_reg.long_ticks;
        assign kcfg.dwin_ticks = cfg_reg.dwin_ticks;

        assign kctl.tick_en   = s_accept && (action == ACT_TICK);
        assign kctl.write_en  = s_accept && (action == ACT_WRITE)
                                && (key_index == KEY_IDX_W'(k));
        assign kctl.pressed   = !key_levels[k];
        assign kctl.write_val = status_value;

        bcc_key_cell u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .kcfg        (kcfg),
            .ctl         (kctl),
            .status_next (status_w[k])
        );
    end

    // Absent keys report no status
    for (genvar k = NUM_CELLS; k < FIELD_KEYS; k++)
    begin : g_absent
        assign status_w[k] = ST_NONE;
    end

    for (genvar k = 0; k < FIELD_KEYS; k++)
    begin : g_pack
        assign result_w[k*STATUS_W +: STATUS_W] = status_w[k];
    end

    // Result register: hold while stalled, load on every accepted word
    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        if (s_accept)
            m_tvalid_next = 1'b1;
        else if (m_tready)
            m_tvalid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tvalid_reg <= 1'b0;
        else
            m_tvalid_reg <= m_tvalid_next;
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
            m_tdata_reg <= result_w;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// File: sv/bcc_checker.sv
// Port-level checks for the button click classifier, bound to the top level.
module bcc_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             s_tvalid,
    input logic                             s_tready,
    input logic [bcc_pkg::IN_DATA_W-1:0]    s_tdata,
    input logic                             s_tuser,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [bcc_pkg::OUT_DATA_W-1:0]   m_tdata
);
    import bcc_pkg::*;

    // A stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    // An empty result register never blocks the input
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty result register");

    // Every accepted word yields a result in the next cycle
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> m_tvalid)
        else $error("accepted word gave no result");

    // A status write to key 0 shows in the next result
    a_write_key0: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && (s_tuser == ACT_WRITE)
        && (s_tdata[LEVEL_W +: KEY_IDX_W] == '0)
        |=> m_tdata[STATUS_W-1:0] == {1'b0, $past(s_tdata[LEVEL_W + KEY_IDX_W])})
        else $error("key 0 status write not reflected");

endmodule

bind button_click_classifier_top bcc_checker u_bcc_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
